### src/kfp_pkg.sv
// kfp_pkg: shared types and constants of the keyed frame pool.
// Field widths, command and status codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package kfp_pkg;

  localparam int unsigned KeyW    = 64;
  localparam int unsigned HandleW = 16;
  localparam int unsigned StatusW = 3;

  // Request command codes
  typedef enum logic {
    CMD_ACTIVATE   = 1'b0,
    CMD_DEACTIVATE = 1'b1
  } cmd_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_REUSED    = 3'd0,
    ST_CREATED   = 3'd1,
    ST_KEYS_FULL = 3'd2,
    ST_LIST_FULL = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_KEY_RD,
    S_KEY_CMP,
    S_CNT_LD,
    S_ACT_DEC,
    S_ACT_RD,
    S_REL_RD,
    S_REL_CMP,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_e;

endpackage

### src/kfp_if.sv
// kfp_req_if / kfp_rsp_if: valid/ready channels of the keyed frame pool.
// Depends on kfp_pkg for the field widths.
`timescale 1ns / 1ps

interface kfp_req_if import kfp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [KeyW-1:0]    class_key;
  logic [HandleW-1:0] handle_in;
  logic [HandleW-1:0] fresh_handle;

  modport source (output valid, command, class_key, handle_in, fresh_handle, input ready);
  modport sink   (input valid, command, class_key, handle_in, fresh_handle, output ready);
endinterface

interface kfp_rsp_if import kfp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [HandleW-1:0] handle_out;
  logic [StatusW-1:0] status;

  modport source (output valid, handle_out, status, input ready);
  modport sink   (input valid, handle_out, status, output ready);
endinterface

### src/kfp_ram.sv
// kfp_ram: simple dual-port memory, one write and one registered read a cycle.
// No dependencies.
`timescale 1ns / 1ps

module kfp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/keyed_frame_pool_core.sv
// keyed_frame_pool_core: per-key pool of frame handles with a free region per list.
// Depends on kfp_pkg, kfp_if (kfp_req_if, kfp_rsp_if) and kfp_ram.
//
//   port    role    handshake     payload
//   req_i   sink    valid/ready   command, class_key, handle_in, fresh_handle
//   rsp_o   source  valid/ready   handle_out, status
//
// One request at a time: an accept step, then a key search that compares the keys one by one
// and then S_DONE. A known key then loads its counts.
// Activate with room in the key table then appends or reports a full list, or reuses.
// Deactivate searches the active region from the top and shifts the match past the rest.
// Reset clears the key count, the sequencer state and the response valid flag only.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps

module keyed_frame_pool_core import kfp_pkg::*; #(
  parameter int unsigned NUM_KEYS        = 16,
  parameter int unsigned HANDLES_PER_KEY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  kfp_req_if.sink   req_i,
  kfp_rsp_if.source rsp_o
);

  localparam int unsigned KW = $clog2(NUM_KEYS + 1);
  localparam int unsigned SW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned CW = $clog2(HANDLES_PER_KEY + 1);
  localparam int unsigned HD = NUM_KEYS * HANDLES_PER_KEY;
  localparam int unsigned AW = (HD > 1) ? $clog2(HD) : 1;

  state_e state_q, state_d;

  // Request holding registers
  cmd_e               cmd_q, cmd_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [HandleW-1:0] hin_q, hin_d;
  logic [HandleW-1:0] fresh_q, fresh_d;

  // Sequencer working registers
  logic [KW-1:0]      key_count_q, key_count_d;
  logic [KW-1:0]      idx_q, idx_d;
  logic [SW-1:0]      slot_q, slot_d;
  logic [CW-1:0]      tot_q, tot_d;
  logic [CW-1:0]      act_q, act_d;
  logic [CW-1:0]      i_q, i_d;
  logic [CW-1:0]      j_q, j_d;
  logic [HandleW-1:0] res_handle_q, res_handle_d;
  status_e            res_status_q, res_status_d;

  // Output register
  logic               rsp_valid_q;
  logic [HandleW-1:0] rsp_handle_q;
  status_e            rsp_status_q;

  // Memory ports
  logic               key_we;
  logic [SW-1:0]      key_waddr;
  logic [KeyW-1:0]    key_rdata;
  logic               cnt_we;
  logic [SW-1:0]      cnt_waddr;
  logic [2*CW-1:0]    cnt_wdata;
  logic [2*CW-1:0]    cnt_rdata;
  logic               hnd_we;
  logic [CW-1:0]      hnd_woff;
  logic [HandleW-1:0] hnd_wdata;
  logic [CW-1:0]      hnd_roff;
  logic [AW-1:0]      hnd_waddr;
  logic [AW-1:0]      hnd_raddr;
  logic [HandleW-1:0] hnd_rdata;
  logic [AW-1:0]      base;

  // Conditions
  logic req_fire, rsp_free;
  logic key_miss, keys_full, key_hit, hnd_hit;
  logic has_free, list_full, search_end, shift_last;

  assign req_fire   = req_i.valid && req_i.ready;
  assign rsp_free   = !rsp_valid_q || rsp_o.ready;
  assign key_miss   = (idx_q == key_count_q);
  assign keys_full  = (key_count_q == KW'(NUM_KEYS));
  assign key_hit    = (key_rdata == key_q);
  assign hnd_hit    = (hnd_rdata == hin_q);
  assign has_free   = (act_q < tot_q);
  assign list_full  = (tot_q >= CW'(HANDLES_PER_KEY));
  assign search_end = (i_q == '0);
  assign shift_last = (j_q == act_q - CW'(1));

  assign base      = AW'(slot_q) * AW'(HANDLES_PER_KEY);
  assign hnd_waddr = base + AW'(hnd_woff);
  assign hnd_raddr = base + AW'(hnd_roff);

  // Memories
  kfp_ram #(.Width(KeyW), .Depth(NUM_KEYS), .AddrW(SW)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_q),
    .raddr_i (idx_q[SW-1:0]),
    .rdata_o (key_rdata)
  );

  kfp_ram #(.Width(2*CW), .Depth(NUM_KEYS), .AddrW(SW)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (idx_q[SW-1:0]),
    .rdata_o (cnt_rdata)
  );

  kfp_ram #(.Width(HandleW), .Depth(HD), .AddrW(AW)) u_hnd_ram (
    .clk_i   (clk_i),
    .we_i    (hnd_we),
    .waddr_i (hnd_waddr),
    .wdata_i (hnd_wdata),
    .raddr_i (hnd_raddr),
    .rdata_o (hnd_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) state_d = S_KEY_RD;
      end
      S_KEY_RD: begin
        if (!key_miss) begin
          state_d = S_KEY_CMP;
        end else if (cmd_q == CMD_DEACTIVATE || keys_full) begin
          state_d = S_DONE;
        end else begin
          state_d = S_ACT_DEC;
        end
      end
      S_KEY_CMP: state_d = key_hit ? S_CNT_LD : S_KEY_RD;
      S_CNT_LD:  state_d = (cmd_q == CMD_ACTIVATE) ? S_ACT_DEC : S_REL_RD;
      S_ACT_DEC: state_d = has_free ? S_ACT_RD : S_DONE;
      S_ACT_RD:  state_d = S_DONE;
      S_REL_RD:  state_d = search_end ? S_DONE : S_REL_CMP;
      S_REL_CMP: state_d = hnd_hit ? S_SH_RD : S_REL_RD;
      S_SH_RD:   state_d = shift_last ? S_DONE : S_SH_WR;
      S_SH_WR:   state_d = S_SH_RD;
      S_DONE: begin
        if (rsp_free) state_d = S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cmd_d        = cmd_q;
    key_d        = key_q;
    hin_d        = hin_q;
    fresh_d      = fresh_q;
    key_count_d  = key_count_q;
    idx_d        = idx_q;
    slot_d       = slot_q;
    tot_d        = tot_q;
    act_d        = act_q;
    i_d          = i_q;
    j_d          = j_q;
    res_handle_d = res_handle_q;
    res_status_d = res_status_q;
    key_we       = 1'b0;
    key_waddr    = key_count_q[SW-1:0];
    cnt_we       = 1'b0;
    cnt_waddr    = slot_q;
    cnt_wdata    = {tot_q, act_q};
    hnd_we       = 1'b0;
    hnd_woff     = j_q;
    hnd_wdata    = hnd_rdata;
    hnd_roff     = act_q;

    unique case (state_q)
      S_IDLE: begin
        // Take the transaction
        if (req_fire) begin
          cmd_d   = cmd_e'(req_i.command);
          key_d   = req_i.class_key;
          hin_d   = req_i.handle_in;
          fresh_d = req_i.fresh_handle;
          idx_d   = '0;
        end
      end
      S_KEY_RD: begin
        res_handle_d = '0;
        if (key_miss) begin
          if (cmd_q == CMD_DEACTIVATE) begin
            res_status_d = ST_NOT_FOUND;
          end else if (keys_full) begin
            res_status_d = ST_KEYS_FULL;
          end else begin
            // Add the key with an empty list
            key_we      = 1'b1;
            cnt_we      = 1'b1;
            cnt_waddr   = key_count_q[SW-1:0];
            cnt_wdata   = '0;
            slot_d      = key_count_q[SW-1:0];
            key_count_d = key_count_q + KW'(1);
            tot_d       = '0;
            act_d       = '0;
          end
        end
      end
      S_KEY_CMP: begin
        if (key_hit) begin
          slot_d = idx_q[SW-1:0];
        end else begin
          idx_d = idx_q + KW'(1);
        end
      end
      S_CNT_LD: begin
        tot_d = cnt_rdata[2*CW-1:CW];
        act_d = cnt_rdata[CW-1:0];
        i_d   = cnt_rdata[CW-1:0];
      end
      S_ACT_DEC: begin
        hnd_roff = act_q;
        if (!has_free) begin
          if (list_full) begin
            res_status_d = ST_LIST_FULL;
          end else begin
            // Append the fresh handle
            hnd_we       = 1'b1;
            hnd_woff     = tot_q;
            hnd_wdata    = fresh_q;
            cnt_we       = 1'b1;
            cnt_wdata    = {tot_q + CW'(1), tot_q + CW'(1)};
            res_handle_d = fresh_q;
            res_status_d = ST_CREATED;
          end
        end
      end
      S_ACT_RD: begin
        // Reuse the first inactive handle
        cnt_we       = 1'b1;
        cnt_wdata    = {tot_q, act_q + CW'(1)};
        res_handle_d = hnd_rdata;
        res_status_d = ST_REUSED;
      end
      S_REL_RD: begin
        hnd_roff = i_q - CW'(1);
        if (search_end) begin
          res_status_d = ST_NOT_FOUND;
        end else begin
          i_d = i_q - CW'(1);
        end
      end
      S_REL_CMP: begin
        j_d = i_q;
      end
      S_SH_RD: begin
        hnd_roff = j_q + CW'(1);
        if (shift_last) begin
          // Park the released handle just past the active region
          hnd_we       = 1'b1;
          hnd_woff     = j_q;
          hnd_wdata    = hin_q;
          cnt_we       = 1'b1;
          cnt_wdata    = {tot_q, act_q - CW'(1)};
          res_status_d = ST_RELEASED;
        end
      end
      S_SH_WR: begin
        // Move the next active handle down one place
        hnd_we    = 1'b1;
        hnd_woff  = j_q;
        hnd_wdata = hnd_rdata;
        j_d       = j_q + CW'(1);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_count_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_count_q <= key_count_d;
      if (state_q == S_DONE && rsp_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    hin_q        <= hin_d;
    fresh_q      <= fresh_d;
    idx_q        <= idx_d;
    slot_q       <= slot_d;
    tot_q        <= tot_d;
    act_q        <= act_d;
    i_q          <= i_d;
    j_q          <= j_d;
    res_handle_q <= res_handle_d;
    res_status_q <= res_status_d;
    if (state_q == S_DONE && rsp_free) begin
      rsp_handle_q <= res_handle_q;
      rsp_status_q <= res_status_q;
    end
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.handle_out = rsp_handle_q;
  assign rsp_o.status     = rsp_status_q;

endmodule

### tb/tb_top.sv
// tb_top: self-checking testbench of keyed_frame_pool_core.
// Depends on kfp_pkg, kfp_if and the core; predicts every grant and release in a model of the pool.
`timescale 1ns / 1ps

module tb_top;
  import kfp_pkg::*;

  localparam int unsigned NUM_KEYS        = 16;
  localparam int unsigned HANDLES_PER_KEY = 16;
  localparam int unsigned KEY_POOL        = 20;
  localparam int unsigned ALPHA           = 6;
  localparam int unsigned RANDOM_ITEMS    = 880;
  localparam int unsigned DRAIN_CYCLES    = 150;
  localparam int unsigned HOLDOFF_AT      = 200;
  localparam int unsigned HOLDOFF_CYCLES  = 400;

  typedef struct packed {
    cmd_e               command;
    logic [KeyW-1:0]    class_key;
    logic [HandleW-1:0] handle_in;
    logic [HandleW-1:0] fresh_handle;
  } pool_req_t;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    status_e            status;
  } pool_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  kfp_req_if req_if ();
  kfp_rsp_if rsp_if ();

  keyed_frame_pool_core #(
    .NUM_KEYS       (NUM_KEYS),
    .HANDLES_PER_KEY(HANDLES_PER_KEY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the pool
  logic [KeyW-1:0]    shadow_keys    [NUM_KEYS];
  int unsigned        shadow_key_cnt;
  logic [HandleW-1:0] shadow_handles [NUM_KEYS][HANDLES_PER_KEY];
  int unsigned        shadow_total   [NUM_KEYS];
  int unsigned        shadow_active  [NUM_KEYS];

  pool_req_t request_q[$];
  pool_rsp_t grant_q[$];
  pool_rsp_t exp_grant;
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;

  // Sender and receiver pacing
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned holdoff_left;
  int unsigned stall_mode;
  int unsigned mode_left;
  int unsigned pattern_ctr;

  // Stimulus material
  logic [KeyW-1:0]    key_pool    [KEY_POOL];
  logic [HandleW-1:0] handle_alpha[KEY_POOL][ALPHA];

  always #5 clk_i = ~clk_i;

  // Apply one request to the shadow pool and return the grant it yields
  function automatic pool_rsp_t pool_apply(pool_req_t rq);
    int unsigned  slot;
    int unsigned  act;
    int           pos;
    logic [HandleW-1:0] tmp;
    pool_rsp_t    r;
    r.handle = '0;
    r.status = ST_NOT_FOUND;
    slot = NUM_KEYS;
    for (int i = 0; i < shadow_key_cnt; i++) begin
      if (slot == NUM_KEYS && shadow_keys[i] == rq.class_key) slot = i;
    end
    if (rq.command == CMD_ACTIVATE) begin
      // add an unknown key if the table has room
      if (slot == NUM_KEYS) begin
        if (shadow_key_cnt >= NUM_KEYS) begin
          r.status = ST_KEYS_FULL;
          return r;
        end
        slot = shadow_key_cnt;
        shadow_keys[slot]   = rq.class_key;
        shadow_total[slot]  = 0;
        shadow_active[slot] = 0;
        shadow_key_cnt++;
      end
      if (shadow_active[slot] >= shadow_total[slot]) begin
        if (shadow_total[slot] >= HANDLES_PER_KEY) begin
          r.status = ST_LIST_FULL;
        end else begin
          shadow_handles[slot][shadow_total[slot]] = rq.fresh_handle;
          shadow_total[slot]++;
          shadow_active[slot] = shadow_total[slot];
          r.handle = rq.fresh_handle;
          r.status = ST_CREATED;
        end
      end else begin
        r.handle = shadow_handles[slot][shadow_active[slot]];
        shadow_active[slot]++;
        r.status = ST_REUSED;
      end
    end else if (slot != NUM_KEYS) begin
      // search the active region from the top, then bubble the match past it
      act = shadow_active[slot];
      pos = -1;
      for (int i = int'(act) - 1; i >= 0; i--) begin
        if (pos < 0 && shadow_handles[slot][i] == rq.handle_in) pos = i;
      end
      if (pos >= 0) begin
        for (int j = pos; j < int'(act) - 1; j++) begin
          tmp = shadow_handles[slot][j];
          shadow_handles[slot][j]     = shadow_handles[slot][j + 1];
          shadow_handles[slot][j + 1] = tmp;
        end
        shadow_active[slot] = act - 1;
        r.status = ST_RELEASED;
      end
    end
    return r;
  endfunction

  function automatic pool_req_t make_req(cmd_e cmd, logic [KeyW-1:0] key,
                                         logic [HandleW-1:0] hin, logic [HandleW-1:0] fresh);
    pool_req_t rq;
    rq.command      = cmd;
    rq.class_key    = key;
    rq.handle_in    = hin;
    rq.fresh_handle = fresh;
    return rq;
  endfunction

  // Request driver: bursts of transactions separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid        <= 1'b0;
      req_if.command      <= CMD_ACTIVATE;
      req_if.class_key    <= '0;
      req_if.handle_in    <= '0;
      req_if.fresh_handle <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        grant_q.push_back(pool_apply(request_q[0]));
        request_q.delete(0);
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          req_if.valid        <= 1'b1;
          req_if.command      <= request_q[0].command;
          req_if.class_key    <= request_q[0].class_key;
          req_if.handle_in    <= request_q[0].handle_in;
          req_if.fresh_handle <= request_q[0].fresh_handle;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check against the oldest expectation, pace ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      holdoff_left = 0;
      stall_mode   = 0;
      mode_left    = 0;
      pattern_ctr  = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result, handle %h status %0d", $time,
                   rsp_if.handle_out, rsp_if.status);
          fail_count++;
        end else begin
          exp_grant = grant_q[0];
          grant_q.delete(0);
          if (rsp_if.handle_out !== exp_grant.handle) begin
            $display("%0t: handle_out expected %h actual %h", $time,
                     exp_grant.handle, rsp_if.handle_out);
            fail_count++;
          end
          if (rsp_if.status !== exp_grant.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_grant.status, rsp_if.status);
            fail_count++;
          end
        end
        results_seen++;
        if (results_seen == HOLDOFF_AT) holdoff_left = HOLDOFF_CYCLES;
      end
      // hold off once for a long stretch, otherwise follow the stall mode
      if (holdoff_left > 0) begin
        holdoff_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(16, 96);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= ($urandom_range(0, 2) != 0);
          2: begin
            rsp_if.ready <= ((pattern_ctr % 5) < 2);
            pattern_ctr++;
          end
          default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned        k;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] hin;
    logic [HandleW-1:0] fresh;
    cmd_e               cmd;

    rst_ni = 1'b0;
    key_pool[0] = '1;
    key_pool[1] = '0;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < KEY_POOL; i++) begin
      for (int j = 0; j < ALPHA; j++) handle_alpha[i][j] = HandleW'($urandom_range(0, 65535));
    end

    // Directed: unknown key on an empty table
    request_q.push_back(make_req(CMD_DEACTIVATE, key_pool[1], 16'h0000, 16'h0001));
    // Fill one list: zero fresh handle, duplicate all-ones handles, then overflow
    for (int i = 0; i < HANDLES_PER_KEY; i++) begin
      if (i == 0)           fresh = 16'h0000;
      else if (i < 3)       fresh = 16'hFFFF;
      else                  fresh = HandleW'($urandom_range(16'h0100, 16'h7FFF));
      request_q.push_back(make_req(CMD_ACTIVATE, key_pool[0], 16'hFFFF, fresh));
    end
    request_q.push_back(make_req(CMD_ACTIVATE, key_pool[0], 16'h0000, 16'h1234));
    // Release the topmost duplicate, miss on a handle never stored, reuse
    request_q.push_back(make_req(CMD_DEACTIVATE, key_pool[0], 16'hFFFF, 16'h0000));
    request_q.push_back(make_req(CMD_DEACTIVATE, key_pool[0], 16'h8001, 16'hFFFF));
    request_q.push_back(make_req(CMD_ACTIVATE, key_pool[0], 16'h0000, 16'h5555));
    // Second key: miss, create, release, reuse
    request_q.push_back(make_req(CMD_DEACTIVATE, key_pool[1], 16'h8000, 16'h0000));
    request_q.push_back(make_req(CMD_ACTIVATE, key_pool[1], 16'h0000, 16'h8000));
    request_q.push_back(make_req(CMD_DEACTIVATE, key_pool[1], 16'h8000, 16'h0000));
    request_q.push_back(make_req(CMD_ACTIVATE, key_pool[1], 16'hFFFF, 16'h0F0F));

    // Random: mostly pooled keys and known handles, some unknown keys and stray handles
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      k = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4) : $urandom_range(0, KEY_POOL - 1);
      key = ($urandom_range(0, 99) < 8) ? {$urandom, $urandom} : key_pool[k];
      cmd = ($urandom_range(0, 99) < 55) ? CMD_ACTIVATE : CMD_DEACTIVATE;
      hin = ($urandom_range(0, 4) != 0) ? handle_alpha[k][$urandom_range(0, ALPHA - 1)]
                                        : HandleW'($urandom_range(0, 65535));
      fresh = ($urandom_range(0, 3) != 0) ? handle_alpha[k][$urandom_range(0, ALPHA - 1)]
                                          : HandleW'($urandom_range(1, 65535));
      request_q.push_back(make_req(cmd, key, hin, fresh));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: wait for every request to go in and every result to come out
    while (request_q.size() != 0 || grant_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
